@@ rtl/bba_pkg.sv @@
// Shared types and codes for the bitmap block allocator.
`default_nettype none

package bba_pkg;

  localparam int ACTION_W = 2;
  localparam int ID_W     = 4;
  localparam int COUNT_W  = 7;
  localparam int BLK_W    = 6;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;
  localparam int MAX_RESULTS = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PRESET = 2'd0,
    ACT_CREATE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_COUNT,
    S_ALLOC,
    S_DEL
  } state_t;

endpackage

`default_nettype wire

@@ rtl/bba_owner_ram.sv @@
// Owner table storage: one write port, one registered read port.
`default_nettype none

module bba_owner_ram
  import bba_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire logic [ID_W-1:0] wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output logic      [ID_W-1:0] rd_data
);

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
// Top level of the bitmap free-block allocator with per-block owner table.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser: action; tdata: file_id, block_count,
//          |     |                      |        block_index
//  out_    | out | out_tvalid/out_tready| tuser: has_block; tdata: status, block_out;
//          |     |                      | tlast: last result of a request
//  cfg_    | in  | cfg_wr_en            | cfg_wr_data: managed block count
//
// Request sequence: a preset or any other one-result request reports one result. A
// create first counts the free blocks, then reports a refused or empty claim, or
// claims blocks; a delete scans for the file's blocks. n is the managed block
// count; one compare/count unit walks the n entries one per cycle, holding while a
// full output register is not taken during a claim or a delete.
// Reset clears the used bitmap and the owner-valid bits at once; no clearing pass.
// A full output register that is not taken holds the scan in place.
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // file_id[3:0], block_count[10:4], block_index[16:11]
  input  wire logic [1:0]  in_tuser,   // action[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // status[1:0], block_out[7:2]
  output logic             out_tuser,  // has_block
  output logic             out_tlast,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data
);

  // Only the first MAX_RESULTS blocks can ever be managed.
  localparam int DEPTH = (NUM_BLOCKS < MAX_RESULTS) ? NUM_BLOCKS : MAX_RESULTS;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // request fields
  action_t            req_action;
  logic [ID_W-1:0]    req_id;
  logic [COUNT_W-1:0] req_count;
  logic [BLK_W-1:0]   req_index;

  assign req_action = action_t'(in_tuser);
  assign req_id     = in_tdata[3:0];
  assign req_count  = in_tdata[10:4];
  assign req_index  = in_tdata[16:11];

  // state
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_r;
  logic [DEPTH-1:0]   used_r, used_nxt;
  logic [DEPTH-1:0]   owned_r, owned_nxt;   // owner table entry holds a live id
  logic [CW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      free_r, free_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  status_t            one_st_r, one_st_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [IW-1:0]      pend_blk_r, pend_blk_nxt;

  // output register
  logic               out_vld_r;
  status_t            out_st_r;
  logic               out_has_r;
  logic [BLK_W-1:0]   out_blk_r;
  logic               out_last_r;

  // emit request from the sequencer
  logic               emit;
  status_t            emit_st;
  logic               emit_has;
  logic [BLK_W-1:0]   emit_blk;
  logic               emit_last;

  logic               out_free;
  logic               accept;
  logic [CW-1:0]      n_eff;
  logic [IW-1:0]      ptr_idx;
  logic               at_end;

  logic               ram_wr_en;
  logic [IW-1:0]      ram_rd_addr;
  logic [ID_W-1:0]    ram_rd_data;

  assign out_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Saturate the managed count to the storage depth.
  assign n_eff   = (cfg_r > CFG_W'(DEPTH)) ? CW'(DEPTH) : cfg_r[CW-1:0];
  assign ptr_idx = ptr_r[IW-1:0];
  assign at_end  = (ptr_r == n_eff);

  // Read one entry ahead so the owner data lines up with ptr_r.
  assign ram_rd_addr = ptr_nxt[IW-1:0];

  bba_owner_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_owner_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ptr_idx),
    .wr_data (id_r),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_nxt    = state_r;
    used_nxt     = used_r;
    owned_nxt    = owned_r;
    ptr_nxt      = ptr_r;
    free_nxt     = free_r;
    rem_nxt      = rem_r;
    id_nxt       = id_r;
    one_st_nxt   = one_st_r;
    pend_vld_nxt = pend_vld_r;
    pend_blk_nxt = pend_blk_r;
    emit         = 1'b0;
    emit_st      = ST_OK;
    emit_has     = 1'b0;
    emit_blk     = '0;
    emit_last    = 1'b1;
    ram_wr_en    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          id_nxt  = req_id;
          rem_nxt = req_count;
          ptr_nxt = '0;
          case (req_action)
            ACT_PRESET: begin
              state_nxt = S_ONE;
              if (COUNT_W'(req_index) >= COUNT_W'(n_eff)) begin
                one_st_nxt = ST_BAD_INDEX;
              end else begin
                one_st_nxt = ST_OK;
                used_nxt[req_index[IW-1:0]] = 1'b1;
              end
            end
            ACT_CREATE: begin
              if (req_id == '0) begin
                state_nxt  = S_ONE;
                one_st_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_COUNT;
                free_nxt  = '0;
              end
            end
            ACT_DELETE: begin
              if (req_id == '0) begin
                state_nxt  = S_ONE;
                one_st_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt    = S_DEL;
                pend_vld_nxt = 1'b0;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ONE: begin
        emit    = out_free;
        emit_st = one_st_r;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      S_COUNT: begin
        if (at_end) begin
          ptr_nxt = '0;
          if (rem_r > COUNT_W'(free_r)) begin
            state_nxt  = S_ONE;
            one_st_nxt = ST_NO_SPACE;
          end else if (rem_r == '0) begin
            state_nxt  = S_ONE;
            one_st_nxt = ST_OK;
          end else begin
            state_nxt = S_ALLOC;
          end
        end else begin
          if (!used_r[ptr_idx]) begin
            free_nxt = free_r + CW'(1);
          end
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      S_ALLOC: begin
        // The free count guarantees rem_r free blocks below n_eff.
        if (used_r[ptr_idx]) begin
          ptr_nxt = ptr_r + CW'(1);
        end else if (out_free) begin
          emit      = 1'b1;
          emit_has  = 1'b1;
          emit_blk  = BLK_W'(ptr_idx);
          emit_last = (rem_r == COUNT_W'(1));
          used_nxt[ptr_idx]  = 1'b1;
          owned_nxt[ptr_idx] = 1'b1;
          ram_wr_en = 1'b1;
          rem_nxt   = rem_r - COUNT_W'(1);
          ptr_nxt   = ptr_r + CW'(1);
          if (rem_r == COUNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DEL: begin
        if (at_end) begin
          // Flush the held block as the last result, or report not found.
          if (out_free) begin
            emit         = 1'b1;
            emit_st      = pend_vld_r ? ST_OK : ST_NOT_FOUND;
            emit_has     = pend_vld_r;
            emit_blk     = pend_vld_r ? BLK_W'(pend_blk_r) : '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end else if (owned_r[ptr_idx] && (ram_rd_data == id_r)) begin
          if (!pend_vld_r || out_free) begin
            emit      = pend_vld_r;
            emit_has  = 1'b1;
            emit_blk  = BLK_W'(pend_blk_r);
            emit_last = 1'b0;
            pend_vld_nxt = 1'b1;
            pend_blk_nxt = ptr_idx;
            used_nxt[ptr_idx]  = 1'b0;
            owned_nxt[ptr_idx] = 1'b0;
            ptr_nxt = ptr_r + CW'(1);
          end
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cfg_r      <= CFG_RESET;
      used_r     <= '0;
      owned_r    <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      used_r     <= used_nxt;
      owned_r    <= owned_nxt;
      pend_vld_r <= pend_vld_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    free_r     <= free_nxt;
    rem_r      <= rem_nxt;
    id_r       <= id_nxt;
    one_st_r   <= one_st_nxt;
    pend_blk_r <= pend_blk_nxt;
    if (emit) begin
      out_st_r   <= emit_st;
      out_has_r  <= emit_has;
      out_blk_r  <= emit_blk;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_blk_r, out_st_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  // An owner entry is live only on a used block.
  a_owned_used: assert property (@(posedge clk) disable iff (!rst_n)
    (owned_r & ~used_r) == '0)
    else $error("owner valid on a free block");

  // Allocation never runs with nothing left to claim.
  a_alloc_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> (rem_r != '0) && (rem_r <= COUNT_W'(free_r)))
    else $error("allocation remainder out of range");

  // A held delete result lives only inside the delete scan.
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> state_r == S_DEL)
    else $error("held block outside delete scan");

  // The sequencer never overwrites a result that is still waiting.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result register overrun");

  // Scan pointer stays within the managed range.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COUNT || state_r == S_ALLOC || state_r == S_DEL) |-> ptr_r <= n_eff)
    else $error("scan pointer past managed range");

endmodule

`default_nettype wire
